// File: rtl/core/kpi_pkg.sv
// ----------------------------------------------------------------------------
// kpi_pkg
// Shared constants and types for the keyframe pose interpolator.
// ----------------------------------------------------------------------------
package kpi_pkg;
  localparam int MAX_KEYS  = 16;
  localparam int KEY_W     = $clog2(MAX_KEYS);
  localparam int CNT_W     = 5;
  localparam int FRAC_BITS = 16;
  localparam int VAL_W     = 32;
  localparam int NUM_COORD = 6;
  localparam int POSE_W    = VAL_W * NUM_COORD;
  localparam int DIV_W     = VAL_W + FRAC_BITS;
  localparam int T_W       = FRAC_BITS + 1;
  localparam int PROD_W    = (VAL_W + 1) + (T_W + 1);

  localparam logic REG_COUNT = 1'b0;
  localparam logic REG_LOOP  = 1'b1;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_EVAL  = 1'b1;

  typedef logic [VAL_W-1:0] val_t;
  typedef logic [POSE_W-1:0] pose_t;
endpackage

// File: rtl/core/keyframe_pose_interpolator.sv
// ----------------------------------------------------------------------------
// keyframe_pose_interpolator
// Keyframe table with piecewise linear pose evaluation over one shared divider
// and one multiplier under a small sequencer.
// ----------------------------------------------------------------------------
//   channel  handshake            words
//   in       in_valid/in_stall    keyframe write or evaluate request
//   out      out_valid/out_stall  interpolated pose
//   cfg      cfg_valid/cfg_ready  keyframe_count, loop_enable
//
// An evaluate word steps, as needed, through the wrap divide when looping, the
// search over the segment times, the fraction divide, a fetch of the two pose
// entries and a multiply and an add per coordinate. in_stall is high until it is done.
// Reset clears the sequencer, out_valid and the configuration registers; the
// tables are undefined until written. A finished pose waits in the output
// register while out_stall holds.
module keyframe_pose_interpolator (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      action,
  input  logic [kpi_pkg::KEY_W-1:0] key_index,
  input  logic [31:0]               key_time,
  input  logic signed [31:0]        key_pos_x,
  input  logic signed [31:0]        key_pos_y,
  input  logic signed [31:0]        key_pos_z,
  input  logic signed [31:0]        key_look_x,
  input  logic signed [31:0]        key_look_y,
  input  logic signed [31:0]        key_look_z,
  input  logic [31:0]               elapsed_time,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [31:0]        pose_pos_x,
  output logic signed [31:0]        pose_pos_y,
  output logic signed [31:0]        pose_pos_z,
  output logic signed [31:0]        pose_look_x,
  output logic signed [31:0]        pose_look_y,
  output logic signed [31:0]        pose_look_z,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic                      cfg_index,
  input  logic [kpi_pkg::CNT_W-1:0] cfg_data
);
  import kpi_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ENDW = 4'd1;
  localparam logic [3:0] S_END  = 4'd2;
  localparam logic [3:0] S_MOD  = 4'd3;
  localparam logic [3:0] S_TAW  = 4'd4;
  localparam logic [3:0] S_TA   = 4'd5;
  localparam logic [3:0] S_TBW  = 4'd6;
  localparam logic [3:0] S_TB   = 4'd7;
  localparam logic [3:0] S_DIV  = 4'd8;
  localparam logic [3:0] S_PAW  = 4'd9;
  localparam logic [3:0] S_PA   = 4'd10;
  localparam logic [3:0] S_PBW  = 4'd11;
  localparam logic [3:0] S_PB   = 4'd12;
  localparam logic [3:0] S_MUL  = 4'd13;
  localparam logic [3:0] S_ADD  = 4'd14;
  localparam logic [3:0] S_OUT  = 4'd15;

  localparam int CIDX_W = $clog2(NUM_COORD);

  logic [3:0]       state;
  logic [CNT_W-1:0] keyframe_count;
  logic             loop_enable;
  logic [CNT_W-1:0] n;
  logic [CNT_W-1:0] seg;
  logic [KEY_W-1:0] tm_addr;
  logic [KEY_W-1:0] pose_addr;
  logic             emit_pending;
  val_t             rt;
  val_t             ta;
  logic [T_W-1:0]   t;
  pose_t            pa;
  pose_t            pb;
  pose_t            res;
  pose_t            res_out;
  logic [CIDX_W-1:0] c;
  logic signed [PROD_W-1:0] prod;

  logic             wr_en;
  val_t             tm_rdata;
  pose_t            pose_rdata;
  pose_t            pose_wdata;
  logic [CNT_W-1:0] n_eff;
  logic [CNT_W-1:0] last;

  logic             div_start;
  logic [DIV_W-1:0] div_dividend;
  val_t             div_divisor;
  logic             div_done;
  logic [DIV_W-1:0] div_quot;
  val_t             div_rem;

  val_t             a_sel;
  val_t             b_sel;
  logic signed [VAL_W:0] diff;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign wr_en     = in_valid && !in_stall && (action == ACT_WRITE);
  assign pose_wdata = {key_look_z, key_look_y, key_look_x, key_pos_z, key_pos_y, key_pos_x};
  assign n_eff = (keyframe_count > CNT_W'(MAX_KEYS)) ? CNT_W'(MAX_KEYS) : keyframe_count;
  assign last  = n - 1'b1;

  assign a_sel = pa[c*VAL_W +: VAL_W];
  assign b_sel = pb[c*VAL_W +: VAL_W];
  assign diff  = $signed({b_sel[VAL_W-1], b_sel}) - $signed({a_sel[VAL_W-1], a_sel});

  assign pose_pos_x  = res_out[0*VAL_W +: VAL_W];
  assign pose_pos_y  = res_out[1*VAL_W +: VAL_W];
  assign pose_pos_z  = res_out[2*VAL_W +: VAL_W];
  assign pose_look_x = res_out[3*VAL_W +: VAL_W];
  assign pose_look_y = res_out[4*VAL_W +: VAL_W];
  assign pose_look_z = res_out[5*VAL_W +: VAL_W];

  kpi_ram #(.WIDTH(VAL_W), .DEPTH(MAX_KEYS)) u_time_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (key_index),
    .wdata (key_time),
    .raddr (tm_addr),
    .rdata (tm_rdata)
  );

  kpi_ram #(.WIDTH(POSE_W), .DEPTH(MAX_KEYS)) u_pose_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (key_index),
    .wdata (pose_wdata),
    .raddr (pose_addr),
    .rdata (pose_rdata)
  );

  kpi_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  always_comb begin
    div_start    = 1'b0;
    div_dividend = {{FRAC_BITS{1'b0}}, rt};
    div_divisor  = tm_rdata;
    if (state == S_END && tm_rdata != '0 && loop_enable) begin
      div_start = 1'b1;
    end else if (state == S_TB && rt >= ta && rt <= tm_rdata && tm_rdata != ta) begin
      div_start    = 1'b1;
      div_dividend = {VAL_W'(rt - ta), {FRAC_BITS{1'b0}}};
      div_divisor  = VAL_W'(tm_rdata - ta);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      keyframe_count <= '0;
      loop_enable    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_COUNT: keyframe_count <= cfg_data;
        REG_LOOP:  loop_enable    <= cfg_data[0];
        default:   keyframe_count <= keyframe_count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      emit_pending <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid && action == ACT_EVAL) begin
            n  <= n_eff;
            rt <= elapsed_time;
            if (n_eff == CNT_W'(1)) begin
              pose_addr    <= '0;
              emit_pending <= 1'b1;
              state        <= S_PAW;
            end else if (n_eff != '0) begin
              tm_addr <= KEY_W'(n_eff - 1'b1);
              state   <= S_ENDW;
            end
          end
        end
        S_ENDW: state <= S_END;
        S_END: begin
          if (tm_rdata == '0 || (!loop_enable && rt >= tm_rdata)) begin
            pose_addr    <= KEY_W'(last);
            emit_pending <= 1'b1;
            state        <= S_PAW;
          end else if (loop_enable) begin
            state <= S_MOD;
          end else begin
            seg     <= '0;
            tm_addr <= '0;
            state   <= S_TAW;
          end
        end
        S_MOD: begin
          if (div_done) begin
            rt      <= div_rem;
            seg     <= '0;
            tm_addr <= '0;
            state   <= S_TAW;
          end
        end
        S_TAW: state <= S_TA;
        S_TA: begin
          ta      <= tm_rdata;
          tm_addr <= KEY_W'(seg + 1'b1);
          state   <= S_TBW;
        end
        S_TBW: state <= S_TB;
        S_TB: begin
          if (rt >= ta && rt <= tm_rdata) begin
            pose_addr <= KEY_W'(seg);
            if (tm_rdata == ta) begin
              t     <= '0;
              state <= S_PAW;
            end else begin
              state <= S_DIV;
            end
          end else if (seg + CNT_W'(2) < n) begin
            seg     <= seg + 1'b1;
            ta      <= tm_rdata;
            tm_addr <= KEY_W'(seg + CNT_W'(2));
            state   <= S_TBW;
          end else begin
            pose_addr    <= KEY_W'(last);
            emit_pending <= 1'b1;
            state        <= S_PAW;
          end
        end
        S_DIV: begin
          if (div_done) begin
            t     <= div_quot[T_W-1:0];
            state <= S_PAW;
          end
        end
        S_PAW: state <= S_PA;
        S_PA: begin
          if (emit_pending) begin
            res          <= pose_rdata;
            emit_pending <= 1'b0;
            state        <= S_OUT;
          end else begin
            pa        <= pose_rdata;
            pose_addr <= pose_addr + 1'b1;
            state     <= S_PBW;
          end
        end
        S_PBW: state <= S_PB;
        S_PB: begin
          pb    <= pose_rdata;
          c     <= '0;
          state <= S_MUL;
        end
        S_MUL: begin
          prod  <= PROD_W'(diff * $signed({1'b0, t}));
          state <= S_ADD;
        end
        S_ADD: begin
          res[c*VAL_W +: VAL_W] <= a_sel + prod[FRAC_BITS +: VAL_W];
          if (c == CIDX_W'(NUM_COORD - 1)) begin
            state <= S_OUT;
          end else begin
            c     <= c + 1'b1;
            state <= S_MUL;
          end
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            res_out   <= res;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && out_valid && out_stall) |=> (state == S_OUT))
    else $error("pose overwritten while output stalled");
  a_div_owner: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_MOD || state == S_DIV))
    else $error("divider finished outside a divide step");
  a_mul_add: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL) |=> (state == S_ADD))
    else $error("product not followed by accumulate");
  a_no_write_busy: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == S_IDLE))
    else $error("table written during evaluation");
`endif
endmodule

// File: rtl/core/kpi_ram.sv
// ----------------------------------------------------------------------------
// kpi_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module kpi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/core/kpi_div.sv
// ----------------------------------------------------------------------------
// kpi_div
// Restoring serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module kpi_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [kpi_pkg::DIV_W-1:0] dividend,
  input  logic [kpi_pkg::VAL_W-1:0] divisor,
  output logic                      done,
  output logic [kpi_pkg::DIV_W-1:0] quot,
  output logic [kpi_pkg::VAL_W-1:0] rem
);
  import kpi_pkg::*;

  localparam int CNT_BITS = $clog2(DIV_W + 1);

  logic [CNT_BITS-1:0] cnt;
  logic                busy;
  logic [VAL_W-1:0]    dvs;
  logic [VAL_W:0]      rem_sh;
  logic                fits;

  assign rem_sh = {rem, quot[DIV_W-1]};
  assign fits   = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_BITS'(DIV_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
      dvs  <= divisor;
    end else if (busy) begin
      if (fits) begin
        rem  <= VAL_W'(rem_sh - {1'b0, dvs});
        quot <= {quot[DIV_W-2:0], 1'b1};
      end else begin
        rem  <= rem_sh[VAL_W-1:0];
        quot <= {quot[DIV_W-2:0], 1'b0};
      end
    end
  end
endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the keyframe pose interpolator. A directed table of
// keyframe writes, evaluations and register writes is followed by random
// routes; each pose is checked against a typed pose or the behavioral model.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import kpi_pkg::*;

  typedef logic [NUM_COORD-1:0][VAL_W-1:0] coords_t;
  typedef enum logic {ROW_CFG, ROW_WORD} row_kind_e;
  typedef struct {
    row_kind_e kind;
    logic      reg_sel;
    logic [CNT_W-1:0] reg_val;
    logic      act;
    logic [KEY_W-1:0] idx;
    val_t      ktime;
    coords_t   key;
    val_t      elapsed;
    bit        typed;
    coords_t   pose;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0, action = ACT_WRITE;
  logic [KEY_W-1:0] key_index = '0;
  logic [31:0] key_time = '0, elapsed_time = '0;
  logic signed [31:0] key_pos_x = '0, key_pos_y = '0, key_pos_z = '0;
  logic signed [31:0] key_look_x = '0, key_look_y = '0, key_look_z = '0;
  logic out_stall = 1'b0, cfg_valid = 1'b0, cfg_index = REG_COUNT;
  logic [CNT_W-1:0] cfg_data = '0;
  logic in_stall, out_valid, cfg_ready;
  logic signed [31:0] pose_pos_x, pose_pos_y, pose_pos_z;
  logic signed [31:0] pose_look_x, pose_look_y, pose_look_z;

  keyframe_pose_interpolator DUT (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  val_t    key_time_tbl [MAX_KEYS];
  coords_t key_val_tbl [MAX_KEYS];
  int      key_count = 0;
  bit      loop_mode = 1'b0;
  coords_t pose_queue [$];
  row_t    dir_rows [$];
  int      err_count = 0;
  int      words_done = 0;
  int      tx_idle_pct = 0, rx_idle_pct = 0;
  bit      hold_req = 1'b0;
  int      hold_left = 0;

  function automatic bit pose_at(input val_t el, output coords_t res);
    int n, last;
    val_t e, rt, ta, tb, dur;
    longint unsigned frac;
    longint sa, diff;
    res = '0;
    n = (key_count > MAX_KEYS) ? MAX_KEYS : key_count;
    if (n == 0) return 1'b0;
    if (n == 1) begin
      res = key_val_tbl[0];
      return 1'b1;
    end
    last = n - 1;
    e = key_time_tbl[last];
    res = key_val_tbl[last];
    if (e == 0) return 1'b1;
    rt = el;
    if (loop_mode) rt = rt % e;
    else if (rt >= e) return 1'b1;
    for (int i = 0; i + 1 < n; i++) begin
      ta = key_time_tbl[i];
      tb = key_time_tbl[i+1];
      if (rt >= ta && rt <= tb) begin
        dur = tb - ta;
        frac = (dur != 0) ? ((64'(rt - ta) << FRAC_BITS) / 64'(dur)) : 64'd0;
        for (int j = 0; j < NUM_COORD; j++) begin
          sa = longint'(signed'(key_val_tbl[i][j]));
          diff = longint'(signed'(key_val_tbl[i+1][j])) - sa;
          res[j] = val_t'(sa + ((diff * longint'(frac)) >>> FRAC_BITS));
        end
        return 1'b1;
      end
    end
    return 1'b1;
  endfunction

  function automatic row_t row_cfg(logic sel, logic [CNT_W-1:0] v);
    row_t r = '{kind: ROW_CFG, default: '0};
    r.kind = ROW_CFG;
    r.reg_sel = sel;
    r.reg_val = v;
    return r;
  endfunction

  function automatic row_t row_write(logic [KEY_W-1:0] i, val_t t, coords_t c);
    row_t r = '{kind: ROW_WORD, default: '0};
    r.kind = ROW_WORD;
    r.act = ACT_WRITE;
    r.idx = i;
    r.ktime = t;
    r.key = c;
    return r;
  endfunction

  function automatic row_t row_eval(val_t el, bit typed, coords_t p);
    row_t r = '{kind: ROW_WORD, default: '0};
    r.kind = ROW_WORD;
    r.act = ACT_EVAL;
    r.elapsed = el;
    r.typed = typed;
    r.pose = p;
    return r;
  endfunction

  task automatic send_word(logic act, logic [KEY_W-1:0] idx, val_t t, coords_t c,
                           val_t el, bit typed, coords_t typed_pose);
    coords_t p;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    key_index <= idx;
    key_time <= t;
    key_pos_x <= c[0];
    key_pos_y <= c[1];
    key_pos_z <= c[2];
    key_look_x <= c[3];
    key_look_y <= c[4];
    key_look_z <= c[5];
    elapsed_time <= el;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (act == ACT_WRITE) begin
      key_time_tbl[idx] = t;
      key_val_tbl[idx] = c;
    end else if (typed) begin
      pose_queue.push_back(typed_pose);
    end else if (pose_at(el, p)) begin
      pose_queue.push_back(p);
    end
    words_done++;
    @(negedge clk);
  endtask

  task automatic write_reg(logic sel, logic [CNT_W-1:0] v);
    in_valid <= 1'b0;
    while (pose_queue.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= sel;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (sel == REG_COUNT) key_count = v;
    else loop_mode = v[0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    coords_t got, want;
    bit bad;
    if (!rst && out_valid && !out_stall) begin
      got = {pose_look_z, pose_look_y, pose_look_x, pose_pos_z, pose_pos_y, pose_pos_x};
      if (pose_queue.size() == 0) begin
        err_count++;
        if (err_count <= 10) $display("unexpected pose word %h", got);
      end else begin
        want = pose_queue.pop_front();
        bad = 1'b0;
        for (int j = 0; j < NUM_COORD; j++) if (got[j] !== want[j]) bad = 1'b1;
        if (bad) begin
          err_count++;
          if (err_count <= 10) $display("pose mismatch: expected %h, got %h", want, got);
        end
      end
    end
  end

  initial begin
    #60_000_000;
    $display("tb failed");
    $finish;
  end

  initial begin
    coords_t c, none;
    val_t tcur, el;
    int n, target;
    bit arm;
    none = '0;
    arm = 1'b0;

    dir_rows.push_back(row_eval(32'd5, 1'b0, none));
    for (int k = 0; k < MAX_KEYS; k++) begin
      for (int j = 0; j < NUM_COORD; j++) c[j] = {k[3:0], 28'h0} + j;
      if (k == 0) c = {NUM_COORD{32'h7FFF_FFFF}};
      if (k == 1) c = {NUM_COORD{32'h8000_0000}};
      if (k == 14) c = '0;
      if (k == 15) c = '1;
      tcur = (k < 2) ? 32'd0 : (k == 15) ? 32'hFFFF_FFFF : k * 32'h0010_0000;
      dir_rows.push_back(row_write(k[3:0], tcur, c));
    end
    dir_rows.push_back(row_cfg(REG_COUNT, 5'd1));
    dir_rows.push_back(row_eval(32'h1234, 1'b1, {NUM_COORD{32'h7FFF_FFFF}}));
    dir_rows.push_back(row_cfg(REG_COUNT, 5'd2));
    dir_rows.push_back(row_eval(32'd7, 1'b1, {NUM_COORD{32'h8000_0000}}));
    dir_rows.push_back(row_cfg(REG_COUNT, 5'd16));
    dir_rows.push_back(row_eval(32'hFFFF_FFFF, 1'b1, '1));
    dir_rows.push_back(row_eval(32'h0018_0000, 1'b0, none));
    dir_rows.push_back(row_eval(32'h0, 1'b0, none));
    dir_rows.push_back(row_cfg(REG_LOOP, 5'd1));
    dir_rows.push_back(row_eval(32'hFFFF_FFFE, 1'b0, none));
    dir_rows.push_back(row_eval(32'hFFFF_FFFF, 1'b0, none));
    dir_rows.push_back(row_cfg(REG_COUNT, 5'd31));
    dir_rows.push_back(row_eval(32'h0025_0000, 1'b0, none));
    dir_rows.push_back(row_cfg(REG_LOOP, 5'd0));
    dir_rows.push_back(row_eval(32'h00F8_0000, 1'b0, none));

    repeat (11) @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_CFG) write_reg(dir_rows[r].reg_sel, dir_rows[r].reg_val);
      else send_word(dir_rows[r].act, dir_rows[r].idx, dir_rows[r].ktime, dir_rows[r].key,
                     dir_rows[r].elapsed, dir_rows[r].typed, dir_rows[r].pose);
    end

    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = (ph == 0) ? 30 : (ph == 1) ? 81 : 0;
      rx_idle_pct = (ph == 0) ? 81 : (ph == 1) ? 30 : 0;
      if (ph == 2) arm = 1'b1;
      target = words_done + 600;
      while (words_done < target) begin
        case ($urandom_range(9))
          0: n = 0;
          1: n = 1;
          2: n = 16;
          3: n = $urandom_range(17, 31);
          default: n = $urandom_range(2, 15);
        endcase
        write_reg(REG_COUNT, n[CNT_W-1:0]);
        write_reg(REG_LOOP, 5'($urandom_range(1)));
        if (n > MAX_KEYS) n = MAX_KEYS;
        if (arm && n > 0) begin
          hold_req = 1'b1;
          arm = 1'b0;
        end
        tcur = ($urandom_range(3) == 0) ? 32'd0 : $urandom_range(0, 1 << 20);
        for (int k = 0; k < n; k++) begin
          if ($urandom_range(9) != 0) begin
            for (int j = 0; j < NUM_COORD; j++) c[j] = $urandom;
            send_word(ACT_WRITE, k[3:0], ($urandom_range(9) == 0) ? $urandom : tcur,
                      c, $urandom, 1'b0, none);
          end
          case ($urandom_range(3))
            0: tcur = tcur;
            1: tcur = tcur + $urandom_range(1, 255);
            default: tcur = tcur + $urandom_range(1, 1 << 26);
          endcase
        end
        repeat (20) begin
          case ($urandom_range(5))
            0: el = $urandom;
            1: el = key_time_tbl[$urandom_range(MAX_KEYS - 1)];
            default: el = $urandom_range(0, tcur + tcur / 4);
          endcase
          if ($urandom_range(19) == 0) begin
            for (int j = 0; j < NUM_COORD; j++) c[j] = $urandom;
            send_word(ACT_WRITE, 4'($urandom_range(MAX_KEYS - 1)), $urandom, c, el,
                      1'b0, none);
          end else begin
            send_word(ACT_EVAL, 4'($urandom), $urandom, c, el, 1'b0, none);
          end
        end
      end
    end

    in_valid <= 1'b0;
    while (pose_queue.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (err_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end
endmodule

// File: files.f
rtl/core/kpi_pkg.sv
rtl/core/kpi_ram.sv
rtl/core/kpi_div.sv
rtl/core/keyframe_pose_interpolator.sv
tb/tb.sv
